// File: src/assert_macros.svh
// assertion macros used by the block's top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, ignored while reset is asserted
`define RSCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property, also during reset
`define RSCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/rscb_pkg.sv
// shared types, constants and helpers of the radial background block
package rscb_pkg;

  localparam int unsigned SumW   = 40;
  localparam int unsigned SqW    = 63;
  localparam int unsigned CntW   = 17;
  localparam int unsigned LimW   = 32;
  localparam int unsigned PixW   = 24;
  localparam int unsigned SigmaW = 23;

  localparam logic [SigmaW-1:0] SigmaMax   = 23'h7FFFFF;
  localparam logic [SigmaW-1:0] SigmaEmpty = 23'd1;
  localparam logic [SigmaW-1:0] SigmaFlat  = 23'd3;
  localparam logic [LimW-1:0]   LimMax     = 32'h7FFFFFFF;
  localparam logic [LimW-1:0]   LimMin     = 32'h80000000;
  localparam logic [15:0]       SnrReset   = 16'd1536;

  // configuration register indexes
  localparam logic REG_ADC = 1'b0;
  localparam logic REG_SNR = 1'b1;

  // request kinds
  localparam logic REQ_PIXEL    = 1'b0;
  localparam logic REQ_FINALIZE = 1'b1;

  // one bin's stored state
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]         sumsq;
    logic [CntW-1:0]        cnt;
    logic signed [LimW-1:0] upper;
    logic signed [LimW-1:0] lower;
  } entry_t;

  // saturate a 34 bit signed value to 32 bit signed
  function automatic logic signed [LimW-1:0] sat32(input logic signed [33:0] v);
    logic signed [LimW-1:0] r;
    if (v > 34'sh07FFFFFFF) begin
      r = LimMax;
    end else if (v < -34'sh080000000) begin
      r = LimMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/radial_sigma_clip_background.sv
// radial sigma-clipped background: per-bin accumulation and finalize sequencer
// pixel transaction: ram read at acceptance, then a busy read-modify-write in S_RD;
//   no new pixel is taken until the block is idle again
// finalize transaction: busy through two 64-step divisions and a 32-step root,
//   the root skipped when the variance is not positive, all skipped for an empty bin;
// result strobe right after; out-of-range bins stay idle; busy after reset clearing ram
module radial_sigma_clip_background #(
  parameter int unsigned N_BINS             = 1024,
  parameter int unsigned MAX_PIXELS_PER_BIN = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic signed [23:0] pixel_value_i,
  input  logic [15:0] radius_bin_i,
  input  logic        pixel_valid_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic [15:0] bin_index_o,
  output logic signed [23:0] bin_mean_o,
  output logic [22:0] bin_sigma_o,
  output logic signed [31:0] upper_threshold_o,
  output logic signed [31:0] lower_threshold_o,
  output logic [16:0] bin_count_o
);
  import rscb_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = (N_BINS > 1) ? $clog2(N_BINS) : 1;
  localparam logic [AW-1:0]   LastBin = AW'(N_BINS - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_PIXELS_PER_BIN);
  localparam logic [16:0]     NumBins = 17'(N_BINS);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_DIV1   = 3'd3;
  localparam logic [2:0] S_DIV2   = 3'd4;
  localparam logic [2:0] S_SQRT   = 3'd5;
  localparam logic [2:0] S_SPREAD = 3'd6;
  localparam logic [2:0] S_LIM    = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q;
  logic          req_q, pv_q, empty_q, neg_q, valid_q;
  logic signed [PixW-1:0] val_q;
  logic [AW-1:0] bin_q;
  logic [46:0]   sq_q;
  entry_t        ent_q, rd, wdata;
  logic signed [24:0] mean_q;
  logic [47:0]   msq_q;
  logic [SigmaW-1:0] sigma_q;
  logic [30:0]   spread_q;
  logic signed [31:0] adc_q;
  logic [15:0]   snr_q;
  logic          accept, in_range;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic        div_start, div_done, div_busy;
  logic [63:0] div_dvd, div_quot;
  logic [16:0] div_dsr;
  logic        sq_start, sq_done;
  logic [63:0] sq_rad;
  logic [32:0] sq_root;

  logic        pix_ok;
  logic [39:0] mag;
  logic signed [64:0] var_w;
  logic signed [33:0] up_w, lo_w;
  logic signed [49:0] msq_full;
  logic signed [31:0] up_sat, lo_sat;

  assign accept   = start && !busy;
  assign in_range = {1'b0, radius_bin_i} < NumBins;
  assign busy     = state_q != S_IDLE;
  assign rd       = entry_t'(ram_rdata);

  rscb_ram #(.WIDTH($bits(entry_t)), .DEPTH(N_BINS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (ram_rdata)
  );

  rscb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rscb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // pixel acceptance test: valid flag, stored clip limits and bin count limit
  assign pix_ok = pv_q
               && ($signed({{8{val_q[23]}}, val_q}) > rd.lower)
               && ($signed({{8{val_q[23]}}, val_q}) < rd.upper)
               && (rd.cnt < MaxCnt);

  assign mag      = rd.sum[39] ? 40'(-rd.sum) : 40'(rd.sum);
  assign msq_full = mean_q * mean_q;
  assign var_w    = $signed({2'b00, div_quot[62:0]}) - $signed({17'd0, msq_q});
  assign up_w     = 34'(mean_q) + $signed({3'b000, spread_q});
  assign lo_w     = 34'(mean_q) - $signed({3'b000, spread_q});
  assign up_sat   = sat32((up_w < 34'(adc_q)) ? 34'(adc_q) : up_w);
  assign lo_sat   = sat32(lo_w);

  // divider and root operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = 64'(mag) + 64'(rd.cnt >> 1);
    div_dsr   = ent_q.cnt;
    sq_start  = 1'b0;
    sq_rad    = 64'(var_w);
    if (state_q == S_RD && req_q == REQ_FINALIZE && rd.cnt != '0) begin
      div_start = 1'b1;
      div_dsr   = rd.cnt;
    end else if (state_q == S_DIV1 && div_done) begin
      div_start = 1'b1;
      div_dvd   = {1'b0, ent_q.sumsq};
    end
    if (state_q == S_DIV2 && div_done && var_w > 65'sd0) begin
      sq_start = 1'b1;
    end
  end

  // ram port control, write data and next state
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = bin_q;
    wdata    = rd;
    state_d  = state_q;
    case (state_q)
      S_CLR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_q;
        wdata.sum   = '0;
        wdata.sumsq = '0;
        wdata.cnt   = '0;
        wdata.upper = LimMax;
        wdata.lower = LimMin;
        if (clr_q == LastBin) state_d = S_IDLE;
      end
      S_IDLE: begin
        ram_addr = radius_bin_i[AW-1:0];
        if (accept && in_range) state_d = S_RD;
      end
      S_RD: begin
        wdata.sum   = rd.sum + 40'(val_q);
        wdata.sumsq = rd.sumsq + 63'(sq_q);
        wdata.cnt   = rd.cnt + 17'd1;
        if (req_q == REQ_PIXEL) begin
          ram_we  = pix_ok;
          state_d = S_IDLE;
        end else if (rd.cnt == '0) begin
          state_d = S_LIM;
        end else begin
          state_d = S_DIV1;
        end
      end
      S_DIV1: if (div_done) state_d = S_DIV2;
      S_DIV2: begin
        if (div_done) state_d = (var_w > 65'sd0) ? S_SQRT : S_SPREAD;
      end
      S_SQRT: if (sq_done) state_d = S_SPREAD;
      S_SPREAD: state_d = S_LIM;
      S_LIM: begin
        ram_we      = 1'b1;
        wdata.sum   = '0;
        wdata.sumsq = '0;
        wdata.cnt   = '0;
        wdata.upper = empty_q ? LimMax : up_sat;
        wdata.lower = empty_q ? LimMin : lo_sat;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      valid_q <= 1'b0;
      adc_q   <= '0;
      snr_q   <= SnrReset;
    end else begin
      state_q <= state_d;
      valid_q <= state_q == S_LIM;
      if (state_q == S_CLR) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ADC: adc_q <= cfg_data_i;
          REG_SNR: snr_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      val_q <= pixel_value_i;
      pv_q  <= pixel_valid_i;
      bin_q <= radius_bin_i[AW-1:0];
      sq_q  <= 47'(pixel_value_i * pixel_value_i);
    end
    msq_q <= msq_full[47:0];
    case (state_q)
      S_RD: begin
        ent_q   <= rd;
        neg_q   <= rd.sum[39];
        empty_q <= rd.cnt == '0;
      end
      S_DIV1: begin
        if (div_done) begin
          mean_q <= neg_q ? -$signed(div_quot[24:0]) : $signed(div_quot[24:0]);
        end
      end
      S_DIV2: begin
        if (div_done && !(var_w > 65'sd0)) sigma_q <= SigmaFlat;
      end
      S_SQRT: begin
        if (sq_done) begin
          sigma_q <= (sq_root > 33'(SigmaMax)) ? SigmaMax : sq_root[22:0];
        end
      end
      S_SPREAD: begin
        spread_q <= 31'((40'(snr_q) * 40'(sigma_q) + 40'd128) >> 8);
      end
      S_LIM: begin
        bin_index_o       <= 16'(bin_q);
        bin_mean_o        <= empty_q ? 24'sd0 : mean_q[23:0];
        bin_sigma_o       <= empty_q ? SigmaEmpty : sigma_q;
        upper_threshold_o <= empty_q ? LimMax : up_sat;
        lower_threshold_o <= empty_q ? LimMin : lo_sat;
        bin_count_o       <= ent_q.cnt;
      end
      default: ;
    endcase
  end

  assign valid_o = valid_q;

  `RSCB_ASSERT(a_valid_after_lim, valid_o |-> $past(state_q == S_LIM), "result without finalize")
  `RSCB_ASSERT(a_valid_single, valid_o |-> !busy || $past(state_q == S_LIM), "stray result strobe")
  `RSCB_ASSERT(a_div_idle_on_start, div_start |-> !div_busy, "divider started while busy")
  `RSCB_ASSERT_ALWAYS(a_clr_busy, (state_q == S_CLR) |-> busy, "accepting during clear")

endmodule

// File: src/rscb_ram.sv
// generic single port ram with registered read
module rscb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rscb_div.sv
// restoring divider, one quotient bit per cycle
module rscb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [16:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quot_o
);
  import rscb_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [17:0] rem_q;
  logic [16:0] dsr_q;
  logic [17:0] rem_n;
  logic        ge;

  assign rem_n = {rem_q[16:0], dvd_q[63]};
  assign ge    = rem_n >= {1'b0, dsr_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd63;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= ge ? (rem_n - {1'b0, dsr_q}) : rem_n;
      dvd_q <= {dvd_q[62:0], ge};
    end else if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// File: src/rscb_sqrt.sv
// digit by digit square root, rounded to nearest, two radicand bits per cycle
module rscb_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [32:0] root_o
);
  import rscb_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [35:0] rem_q;
  logic [31:0] res_q;
  logic [35:0] rem_n, trial;
  logic        ge;

  assign rem_n = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, res_q, 2'b01};
  assign ge    = rem_n >= trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      rem_q <= ge ? (rem_n - trial) : rem_n;
      res_q <= {res_q[30:0], ge};
    end else if (start_i) begin
      rad_q <= rad_i;
      rem_q <= '0;
      res_q <= '0;
    end
  end

  // remainder above the root means the true root lies nearer the next integer
  assign root_o = (rem_q > {4'd0, res_q}) ? ({1'b0, res_q} + 33'd1) : {1'b0, res_q};
  assign done_o = done_q;

endmodule

// File: sim/tb.sv
// self-checking testbench for the radial sigma-clipped background block
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rscb_pkg::*;

  localparam int unsigned NBINS   = 1024;
  localparam int unsigned MAXPIX  = 65536;
  localparam int unsigned RND_ITEMS = 1900;

  // one finalize result
  typedef struct packed {
    logic [15:0]        bin;
    logic signed [23:0] mean;
    logic [22:0]        sigma;
    logic signed [31:0] upper;
    logic signed [31:0] lower;
    logic [16:0]        cnt;
  } bin_stats_t;

  // one row of the directed stimulus table
  typedef struct {
    logic               rt;
    logic signed [23:0] val;
    logic [15:0]        bin;
    logic               pv;
    bit                 typed;
    bin_stats_t         stats;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic req_type, pixel_valid;
  logic signed [23:0] pixel_value;
  logic [15:0] radius_bin;
  logic cfg_we, cfg_idx;
  logic [31:0] cfg_data;
  logic valid_o;
  logic [15:0] bin_index_o;
  logic signed [23:0] bin_mean_o;
  logic [22:0] bin_sigma_o;
  logic signed [31:0] upper_threshold_o, lower_threshold_o;
  logic [16:0] bin_count_o;

  // typed expectation that travels with the current transaction
  logic       row_typed;
  bin_stats_t row_stats;

  // shadow state of the bins and registers
  longint          sum_sh   [NBINS];
  longint unsigned sumsq_sh [NBINS];
  int unsigned     cnt_sh   [NBINS];
  longint          upper_sh [NBINS];
  longint          lower_sh [NBINS];
  longint          adc_sh;
  longint          snr_sh;

  bin_stats_t stats_q[$];
  int unsigned mismatches;
  bit idle_on;

  radial_sigma_clip_background dut (
    .clk_i, .rst_ni, .start, .busy,
    .req_type_i(req_type), .pixel_value_i(pixel_value),
    .radius_bin_i(radius_bin), .pixel_valid_i(pixel_valid),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .valid_o, .bin_index_o, .bin_mean_o, .bin_sigma_o,
    .upper_threshold_o, .lower_threshold_o, .bin_count_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // integer square root, rounded to nearest
  function automatic longint unsigned root_rounded(input longint unsigned v);
    longint unsigned s, t;
    s = 0;
    for (int b = 31; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if (t * t <= v) s = t;
    end
    if (v - s * s > s) s++;
    return s;
  endfunction

  // clip a wide value to 32 bit signed
  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // close one bin: statistics, new limits, cleared accumulators
  function automatic bin_stats_t close_bin(input int unsigned b);
    bin_stats_t r;
    longint mean, ex2, var_v, spread, up, lo;
    longint unsigned mag, q, sig;
    int unsigned n;
    n = cnt_sh[b];
    if (n == 0) begin
      mean = 0; sig = 1; up = 64'sd2147483647; lo = -64'sd2147483648;
    end else begin
      mag = (sum_sh[b] < 0) ? -sum_sh[b] : sum_sh[b];
      q = (mag + n / 2) / n;
      mean = (sum_sh[b] < 0) ? -longint'(q) : longint'(q);
      ex2 = longint'(sumsq_sh[b] / n);
      var_v = ex2 - mean * mean;
      if (var_v > 0) begin
        sig = root_rounded(var_v);
        if (sig > 8388607) sig = 8388607;
      end else begin
        sig = 3;
      end
      spread = longint'((longint'(snr_sh) * sig + 128) >>> 8);
      up = mean + spread;
      if (up < adc_sh) up = adc_sh;
      up = clip32(up);
      lo = clip32(mean - spread);
    end
    upper_sh[b] = up; lower_sh[b] = lo;
    sum_sh[b] = 0; sumsq_sh[b] = 0; cnt_sh[b] = 0;
    r.bin = 16'(b); r.mean = 24'(mean); r.sigma = 23'(sig);
    r.upper = 32'(up); r.lower = 32'(lo); r.cnt = 17'(n);
    return r;
  endfunction

  // add one pixel into its bin when it is valid, passes the clip limits and the bin is not full
  function automatic void add_pixel(input longint v, input int unsigned b, input logic pv);
    if (!pv) return;
    if (!(v > lower_sh[b] && v < upper_sh[b])) return;
    if (cnt_sh[b] >= MAXPIX) return;
    sum_sh[b] += v;
    sumsq_sh[b] += longint'(v * v);
    cnt_sh[b]++;
  endfunction

  // monitor: register mirror, prediction at acceptance, result checking
  always @(posedge clk_i) begin
    bin_stats_t got, want, pred;
    if (rst_ni) begin
      if (valid_o) begin
        got = '{bin_index_o, bin_mean_o, bin_sigma_o, upper_threshold_o,
                lower_threshold_o, bin_count_o};
        if (stats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result for bin %0d", bin_index_o);
        end else begin
          want = stats_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("bin %0d: exp mean %0d sigma %0d up %0d lo %0d cnt %0d",
                       want.bin, want.mean, want.sigma, want.upper, want.lower, want.cnt,
                       " / got bin %0d mean %0d sigma %0d up %0d lo %0d cnt %0d",
                       got.bin, got.mean, got.sigma, got.upper, got.lower, got.cnt);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == REG_ADC) adc_sh = longint'($signed(cfg_data));
        else snr_sh = cfg_data[15:0];
      end
      if (start && !busy && radius_bin < NBINS) begin
        if (req_type == REQ_PIXEL) begin
          add_pixel(pixel_value, radius_bin, pixel_valid);
        end else begin
          pred = close_bin(radius_bin);
          stats_q.push_back(row_typed ? row_stats : pred);
        end
      end
    end
  end

  // drive one transaction, wait for it to be taken, and at times pause before the next
  task automatic issue(input logic rt, input logic signed [23:0] v, input logic [15:0] b,
                       input logic pv, input bit typed, input bin_stats_t st);
    start <= 1'b1;
    req_type <= rt; pixel_value <= v; radius_bin <= b; pixel_valid <= pv;
    row_typed <= typed; row_stats <= st;
    do @(posedge clk_i); while (busy);
    if (idle_on && $urandom_range(99) < 9) begin
      start <= 1'b0;
      row_typed <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic pixel(input logic signed [23:0] v, input logic [15:0] b, input logic pv);
    issue(REQ_PIXEL, v, b, pv, 1'b0, '0);
  endtask

  task automatic finalize(input logic [15:0] b);
    issue(REQ_FINALIZE, 24'($urandom), b, 1'($urandom), 1'b0, '0);
  endtask

  // stop sending until every expected result is in and the block is quiet
  task automatic drain();
    start <= 1'b0;
    row_typed <= 1'b0;
    do @(posedge clk_i); while (stats_q.size() != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] d);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  stim_row_t dir_tab[$];

  initial begin
    bin_stats_t empty_st;
    int unsigned act_bin[8];
    longint centre[8];
    int unsigned sent, k, nb;
    longint v;
    logic [31:0] adc_set[5];
    logic [15:0] snr_set[5];

    rst_ni = 1'b0; start = 1'b0; req_type = 1'b0; pixel_value = '0;
    radius_bin = '0; pixel_valid = 1'b0; cfg_we = 1'b0; cfg_idx = 1'b0;
    cfg_data = '0; row_typed = 1'b0; row_stats = '0;
    mismatches = 0; idle_on = 1'b1;
    adc_sh = 0; snr_sh = SnrReset;
    for (int i = 0; i < NBINS; i++) begin
      sum_sh[i] = 0; sumsq_sh[i] = 0; cnt_sh[i] = 0;
      upper_sh[i] = 64'sd2147483647; lower_sh[i] = -64'sd2147483648;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table: empty bins, range edges, extremes, flat bins, clipping
    empty_st = '{0, 0, SigmaEmpty, LimMax, LimMin, 0};
    dir_tab.push_back('{REQ_FINALIZE, 24'sh123456, 16'd0, 1'b1, 1'b1, empty_st});
    empty_st.bin = 16'd1023;
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'd1023, 1'b0, 1'b1, empty_st});
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'd1024, 1'b0, 1'b0, '0});
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'hFFFF, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sh7FFFFF, 16'd1023, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, -24'sh800000, 16'd1023, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sh000005, 16'd1023, 1'b0, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sh7FFFFF, 16'hFFFF, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sh7FFFFF, 16'd1024, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'd1023, 1'b0, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sh7FFFFF, 16'd4, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'd4, 1'b0, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sh0, 16'd2, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_FINALIZE, 24'shFFFFFF, 16'd2, 1'b1, 1'b1,
                        '{16'd2, 0, SigmaFlat, 32'sd18, -32'sd18, 17'd1}});
    dir_tab.push_back('{REQ_PIXEL, 24'sd256, 16'd3, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sd256, 16'd3, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'd3, 1'b0, 1'b1,
                        '{16'd3, 24'sd256, SigmaFlat, 32'sd274, 32'sd238, 17'd2}});
    dir_tab.push_back('{REQ_PIXEL, 24'sd274, 16'd3, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sd238, 16'd3, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_PIXEL, 24'sd260, 16'd3, 1'b1, 1'b0, '0});
    dir_tab.push_back('{REQ_FINALIZE, 24'sh0, 16'd3, 1'b0, 1'b1,
                        '{16'd3, 24'sd260, SigmaFlat, 32'sd278, 32'sd242, 17'd1}});
    foreach (dir_tab[i])
      issue(dir_tab[i].rt, dir_tab[i].val, dir_tab[i].bin, dir_tab[i].pv,
            dir_tab[i].typed, dir_tab[i].stats);
    drain();

    // random passes under several register settings, extremes included
    adc_set = '{32'h80000000, 32'h7FFFFFFF, 32'h0, $urandom, $urandom};
    snr_set = '{16'hFFFF, 16'h0, 16'd1536, 16'($urandom), 16'($urandom_range(0, 2048))};
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_ADC, adc_set[ph]);
      write_reg(REG_SNR, 32'(snr_set[ph]));
      for (int j = 0; j < 8; j++) begin
        act_bin[j] = (j == 0) ? 0 : (j == 1) ? NBINS - 1 : $urandom_range(0, NBINS - 1);
        centre[j] = longint'($urandom_range(0, 4000000)) - 2000000;
      end
      while (sent < (ph + 1) * RND_ITEMS / 5) begin
        idle_on = !(sent > 700 && sent < 1100);
        // one pass: pixels of the active bins with some noise, then every active bin closed
        for (int p = 0; p < 40; p++) begin
          k = $urandom_range(0, 7);
          nb = $urandom_range(0, 99);
          if (nb < 4) begin
            pixel(24'($urandom), 16'($urandom_range(NBINS, 65535)), 1'b1);
          end else if (nb < 8) begin
            pixel(24'($urandom), 16'(act_bin[k]), 1'($urandom));
          end else if (nb < 12) begin
            pixel(24'(centre[k]), 16'(act_bin[k]), 1'b0);
          end else begin
            v = centre[k] + longint'($signed($urandom_range(0, 2 << $urandom_range(0, 16))))
                - (longint'(1) << $urandom_range(0, 16));
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            pixel(24'(v), 16'(act_bin[k]), 1'b1);
          end
          sent++;
        end
        for (int j = 0; j < 8; j++) begin
          finalize(16'(act_bin[j]));
          sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
          finalize(16'($urandom_range(NBINS, 65535)));
          sent++;
        end
      end
      drain();
    end

    // wait out the last results
    start <= 1'b0;
    do @(posedge clk_i); while (stats_q.size() != 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && stats_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
